>>> sv/tbsat_pkg.sv
// ----------------------------------------------------------------------------
// tbsat_pkg: shared widths for the triangle / square overlap test
// Coordinate and side widths used by all stages.
// ----------------------------------------------------------------------------
package tbsat_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int SIDE_BITS      = 15;
    localparam logic [SIDE_BITS-1:0] SIDE_RESET = 15'd512;
endpackage

>>> sv/tbsat_edge.sv
// ----------------------------------------------------------------------------
// tbsat_edge: one triangle edge normal axis test
// Stage 1 registers the normal, stage 2 the products, stage 3 the corner sums; compare is combinational.
// ----------------------------------------------------------------------------
module tbsat_edge #(
    parameter int CB = 16
) (
    input  logic                clk,
    input  logic [2:0]          adv,
    input  logic signed [CB:0]  px,
    input  logic signed [CB:0]  py,
    input  logic signed [CB:0]  qx,
    input  logic signed [CB:0]  qy,
    input  logic signed [CB:0]  rx,
    input  logic signed [CB:0]  ry,
    input  logic signed [CB:0]  lx,
    input  logic signed [CB:0]  ty,
    input  logic signed [CB:0]  sd,
    output logic                meet
);
    localparam int PW = 2 * CB + 4;
    logic signed [CB+1:0] nx_reg, ny_reg;
    logic signed [PW-1:0] pp_reg, pr_reg, bl_reg, bs_reg, bt_reg, bu_reg;
    logic signed [PW-1:0] p_reg, r_reg, b0_reg, b1_reg, b2_reg, b3_reg;
    logic signed [PW-1:0] tmin, tmax, bmin, bmax;
    logic signed [CB:0] px1_reg, py1_reg, rx1_reg, ry1_reg, l1_reg, t1_reg, s1_reg;

    // normal of edge P->Q
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            nx_reg  <= (CB+2)'(py) - (CB+2)'(qy);
            ny_reg  <= (CB+2)'(qx) - (CB+2)'(px);
            px1_reg <= px; py1_reg <= py; rx1_reg <= rx; ry1_reg <= ry;
            l1_reg  <= lx; t1_reg  <= ty; s1_reg  <= sd;
        end
    end

    // products; pp_reg and pr_reg each hold a two-term dot product
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pp_reg <= PW'(nx_reg * px1_reg) + PW'(ny_reg * py1_reg);
            pr_reg <= PW'(nx_reg * rx1_reg) + PW'(ny_reg * ry1_reg);
            bl_reg <= PW'(nx_reg * l1_reg);
            bs_reg <= PW'(nx_reg * s1_reg);
            bt_reg <= PW'(ny_reg * t1_reg);
            bu_reg <= PW'(ny_reg * s1_reg);
        end
    end

    // corner projections
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            p_reg  <= pp_reg;
            r_reg  <= pr_reg;
            b0_reg <= bl_reg + bt_reg;
            b1_reg <= bl_reg + bs_reg + bt_reg;
            b2_reg <= bl_reg + bs_reg + bt_reg + bu_reg;
            b3_reg <= bl_reg + bt_reg + bu_reg;
        end
    end

    // Q projects like P on its own normal
    always_comb
    begin
        tmin = (p_reg < r_reg) ? p_reg : r_reg;
        tmax = (p_reg < r_reg) ? r_reg : p_reg;
        bmin = b0_reg; bmax = b0_reg;
        if (b1_reg < bmin) bmin = b1_reg;
        if (b1_reg > bmax) bmax = b1_reg;
        if (b2_reg < bmin) bmin = b2_reg;
        if (b2_reg > bmax) bmax = b2_reg;
        if (b3_reg < bmin) bmin = b3_reg;
        if (b3_reg > bmax) bmax = b3_reg;
        meet = (tmax >= bmin) && (bmax >= tmin);
    end
endmodule

>>> sv/triangle_box_sat_overlap.sv
// ----------------------------------------------------------------------------
// triangle_box_sat_overlap: triangle versus square separating axis test
// Five axes tested in parallel lanes over a four stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// Reset: valid bits clear, side_reg returns to 512.
module triangle_box_sat_overlap
    import tbsat_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tbsat_pkg::SIDE_BITS-1:0] cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] tri_ax,
    input  logic signed [COORD_BITS-1:0] tri_ay,
    input  logic signed [COORD_BITS-1:0] tri_bx,
    input  logic signed [COORD_BITS-1:0] tri_by,
    input  logic signed [COORD_BITS-1:0] tri_cx,
    input  logic signed [COORD_BITS-1:0] tri_cy,
    input  logic signed [COORD_BITS-1:0] box_left,
    input  logic signed [COORD_BITS-1:0] box_top,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         overlap
);
    // internal coordinate width: wide enough for a coordinate and the side
    localparam int CB = (COORD_BITS > SIDE_BITS) ? COORD_BITS : SIDE_BITS + 1;
    logic [SIDE_BITS-1:0] side_reg;
    logic [3:0] v_reg;
    logic [2:0] adv;
    logic go;
    logic [2:0] em;
    logic signed [CB:0] ax, ay, bx, by, cx, cy, l, t, s;
    logic signed [CB+1:0] xr_reg, yr_reg; // right / bottom
    logic signed [CB:0] l_reg, t_reg;
    logic signed [COORD_BITS-1:0] xmn_reg, xmx_reg, ymn_reg, ymx_reg;
    logic signed [COORD_BITS-1:0] xmn, xmx, ymn, ymx;
    logic cart_reg, cart2_reg, ovl_reg;

    // one shared enable: pipeline moves unless output is stalled while valid
    assign go       = !(out_valid && out_stall);
    assign adv      = {3{go}};
    assign in_stall = !go;
    assign out_valid = v_reg[3];
    assign overlap  = ovl_reg;

    assign ax = (CB+1)'(tri_ax); assign ay = (CB+1)'(tri_ay);
    assign bx = (CB+1)'(tri_bx); assign by = (CB+1)'(tri_by);
    assign cx = (CB+1)'(tri_cx); assign cy = (CB+1)'(tri_cy);
    assign l  = (CB+1)'(box_left); assign t = (CB+1)'(box_top);
    assign s  = (CB+1)'($signed({1'b0, side_reg}));

    // config register and valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
            v_reg    <= '0;
        end
        else
        begin
            if (cfg_we) side_reg <= cfg_wdata;
            if (go) v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // cartesian axes: triangle bounding box
    always_comb
    begin
        xmn = tri_ax; xmx = tri_ax; ymn = tri_ay; ymx = tri_ay;
        if (tri_bx < xmn) xmn = tri_bx;
        if (tri_bx > xmx) xmx = tri_bx;
        if (tri_cx < xmn) xmn = tri_cx;
        if (tri_cx > xmx) xmx = tri_cx;
        if (tri_by < ymn) ymn = tri_by;
        if (tri_by > ymx) ymx = tri_by;
        if (tri_cy < ymn) ymn = tri_cy;
        if (tri_cy > ymx) ymx = tri_cy;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            xmn_reg <= xmn; xmx_reg <= xmx; ymn_reg <= ymn; ymx_reg <= ymx;
            l_reg   <= l;   t_reg   <= t;
            xr_reg  <= (CB+2)'(l) + (CB+2)'(s);
            yr_reg  <= (CB+2)'(t) + (CB+2)'(s);
            cart_reg <= ((CB+2)'(xmx_reg) >= (CB+2)'(l_reg)) && (xr_reg >= (CB+2)'(xmn_reg))
                     && ((CB+2)'(ymx_reg) >= (CB+2)'(t_reg)) && (yr_reg >= (CB+2)'(ymn_reg));
            cart2_reg <= cart_reg;
            ovl_reg  <= cart2_reg && (&em);
        end
    end

    // edge normal lanes
    tbsat_edge #(.CB(CB)) u_e0 (.clk(clk), .adv(adv), .px(ax), .py(ay), .qx(bx), .qy(by),
        .rx(cx), .ry(cy), .lx(l), .ty(t), .sd(s), .meet(em[0]));
    tbsat_edge #(.CB(CB)) u_e1 (.clk(clk), .adv(adv), .px(bx), .py(by), .qx(cx), .qy(cy),
        .rx(ax), .ry(ay), .lx(l), .ty(t), .sd(s), .meet(em[1]));
    tbsat_edge #(.CB(CB)) u_e2 (.clk(clk), .adv(adv), .px(cx), .py(cy), .qx(ax), .qy(ay),
        .rx(bx), .ry(by), .lx(l), .ty(t), .sd(s), .meet(em[2]));
endmodule

>>> sv/tbsat_chk.sv
// ----------------------------------------------------------------------------
// tbsat_chk: port level checks for the overlap test
// Handshake and latency checks bound to the top level.
// ----------------------------------------------------------------------------
module tbsat_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic overlap
);
    // output word holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(overlap)) else $error("hold");
    // input stalls only when output is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall) else $error("stall");
    // a word accepted while the output does not stall moves through v_reg[0] to v_reg[3] and shows as out_valid
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("latency");
endmodule

bind triangle_box_sat_overlap tbsat_chk u_chk (.clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
    .out_stall(out_stall), .overlap(overlap));
